// ===== hdl/dcms_pkg.sv =====
// Shared types and constants for the distance cluster block.
package dcms_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_BOX_LENGTH = 2'd0;
  localparam logic [1:0] REG_DIMENSIONS = 2'd1;
  localparam logic [1:0] REG_CUTOFF     = 2'd2;

  localparam int unsigned CfgW = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_PICK,
    ST_FEED,
    ST_WAIT,
    ST_STEP,
    ST_DIVIDE,
    ST_DONE
  } state_e;

  // Per-cell status bits
  typedef struct packed {
    logic valid;
    logic visited;
    logic frontier;
  } flags_t;

  // Control broadcast to the cell row
  typedef struct packed {
    logic shift;      // take neighbor contents
    logic clear;      // drop all entries
    logic set_mark;   // mark visited and frontier
    logic clr_front;  // clear frontier
  } cell_ctl_t;

endpackage

// ===== hdl/dcms_cell.sv =====
// One particle cell of the rotating row.
module dcms_cell #(
  parameter int unsigned CoordW = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dcms_pkg::cell_ctl_t ctl_i,
  input  logic [CoordW-1:0]  crd_i,
  input  dcms_pkg::flags_t   flg_i,
  output logic [CoordW-1:0]  crd_o,
  output dcms_pkg::flags_t   flg_o
);
  import dcms_pkg::*;

  logic [CoordW-1:0] crd_q;
  flags_t            flg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flg_q <= '0;
    end else if (ctl_i.clear) begin
      flg_q <= '0;
    end else if (ctl_i.shift) begin
      flg_q <= flg_i;
    end else begin
      if (ctl_i.set_mark) begin
        flg_q.visited  <= 1'b1;
        flg_q.frontier <= 1'b1;
      end
      if (ctl_i.clr_front) begin
        flg_q.frontier <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      crd_q <= crd_i;
    end
  end

  assign crd_o = crd_q;
  assign flg_o = flg_q;

endmodule

// ===== hdl/dcms_dist.sv =====
// Four-stage minimum-image distance test against the squared cutoff.
module dcms_dist #(
  parameter int unsigned CoordBits = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [3*CoordBits-1:0] probe_i,
  input  logic [3*CoordBits-1:0] elem_i,
  input  logic [1:0]             dims_i,
  input  logic [15:0]            box_i,
  input  logic [31:0]            lim_i,
  output logic                   valid_o,
  output logic                   link_o
);
  import dcms_pkg::*;

  localparam int unsigned DifW = CoordBits + 1;
  localparam int unsigned DW   = ((CoordBits > 16) ? CoordBits : 16) + 3;

  logic [3:0]                   vld_q;
  logic signed [DifW-1:0]       dif_q [3];
  logic [15:0]                  mag_q [3];
  logic [2:0]                   far_d, far_q1, far_q2;
  logic [31:0]                  sq_q [3];
  logic [2:0]                   en;
  logic [33:0]                  sum;
  logic                         link_q;

  assign en = {dims_i > 2'd2, dims_i > 2'd1, dims_i > 2'd0};

  for (genvar a = 0; a < 3; a++) begin : g_ax
    logic signed [CoordBits-1:0] pa, ea;
    logic signed [DW-1:0]        d, d2, boxs, dw, mabs;

    assign pa   = probe_i[a*CoordBits +: CoordBits];
    assign ea   = elem_i[a*CoordBits +: CoordBits];
    assign d    = DW'(dif_q[a]);
    assign d2   = d <<< 1;
    assign boxs = signed'(DW'(box_i));

    always_comb begin
      if (d2 > boxs) begin
        dw = d - boxs;
      end else if (d2 < -boxs) begin
        dw = d + boxs;
      end else begin
        dw = d;
      end
      mabs = (dw < 0) ? -dw : dw;
    end

    assign far_d[a] = en[a] && (mabs[DW-1:16] != '0);

    always_ff @(posedge clk_i) begin
      dif_q[a] <= DifW'(pa) - DifW'(ea);
      mag_q[a] <= en[a] ? mabs[15:0] : 16'd0;
      sq_q[a]  <= mag_q[a] * mag_q[a];
    end
  end

  always_ff @(posedge clk_i) begin
    far_q1 <= far_d;
    far_q2 <= far_q1;
  end

  assign sum = 34'(sq_q[0]) + 34'(sq_q[1]) + 34'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    link_q <= (far_q2 == 3'b000) && (sum < 34'(lim_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  assign valid_o = vld_q[3];
  assign link_o  = link_q;

endmodule

// ===== hdl/dcms_div.sv =====
// Restoring divider, one quotient bit per cycle.
module dcms_div #(
  parameter int unsigned NumW = 9,
  parameter int unsigned DenW = 9
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  import dcms_pkg::*;

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW:0]   rem_q, sh, sub;
  logic [NumW-1:0] quo_q;
  logic [DenW-1:0] den_q;
  logic            ge;

  assign sh  = {rem_q[DenW-1:0], quo_q[NumW-1]};
  assign ge  = sh >= {1'b0, den_q};
  assign sub = sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? sub : sh;
      quo_q <= {quo_q[NumW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== hdl/distance_cluster_mean_size.sv =====
// Top level: particle cell row, flood-fill sequencer, distance unit and divider.
//
// Particles stream in one item per cycle and shift into a row of MAX_PARTICLES
// cells; a full row drops further particles. The item flagged last_particle
// starts clustering and input stalls until the job is done. The row rotates
// past a single observe point at cell 0: a seed pass finds an unvisited
// particle (new cluster), a pick pass finds a frontier particle and latches it
// as the probe, and a compare pass walks the whole row past the probe: each
// particle is fed to the distance pipeline, its verdict is awaited, and then
// the row rotates by one cell. A job runs a pick scan and a compare pass per
// particle, the seed scans for the clusters and finally the mean-size divider.
// The result sits in an output register, so loading the next set may begin
// while it waits to be taken.
module distance_cluster_mean_size #(
  parameter int unsigned MAX_PARTICLES = 256,
  parameter int unsigned COORD_BITS    = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [dcms_pkg::CfgW-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] coord_x_i,
  input  logic [COORD_BITS-1:0] coord_y_i,
  input  logic [COORD_BITS-1:0] coord_z_i,
  input  logic                  last_particle_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [8:0]            cluster_count_o,
  output logic [8:0]            particle_total_o,
  output logic [16:0]           avg_size_o
);
  import dcms_pkg::*;

  localparam int unsigned NW = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned RW = $clog2(MAX_PARTICLES);
  localparam int unsigned CW = 3 * COORD_BITS;
  localparam int unsigned QW = NW + 8;

  // Configuration
  logic [15:0] box_q, cut_q;
  logic [1:0]  dims_q;
  logic [31:0] lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q  <= 16'd2560;
      dims_q <= 2'd3;
      cut_q  <= 16'd512;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BOX_LENGTH: box_q  <= cfg_data_i;
        REG_DIMENSIONS: dims_q <= cfg_data_i[1:0];
        REG_CUTOFF:     cut_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q <= cut_q * cut_q;
  end

  // Control
  state_e          state_q, state_d;
  logic [RW-1:0]   rot_q;
  logic [NW-1:0]   lc_q, n_q, clu_q;
  logic [CW-1:0]   probe_q;
  logic            in_acc, out_acc, full, rot_end;
  logic            seed_hit, pick_hit, mark_hit, go_out;
  logic            rotate, pipe_vld, link_vld, link, div_done;
  logic [QW-1:0]   quo;
  cell_ctl_t       ctl0, ctln;

  logic [CW-1:0]   crd [MAX_PARTICLES];
  flags_t          flg [MAX_PARTICLES];
  logic [CW-1:0]   crd0_in;
  flags_t          flg0_in;

  logic            out_valid_q;
  logic [8:0]      cc_q, pt_q;
  logic [16:0]     ms_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign full       = (lc_q == NW'(MAX_PARTICLES));
  assign rot_end    = (rot_q == RW'(MAX_PARTICLES - 1));
  assign seed_hit   = flg[0].valid && !flg[0].visited;
  assign pick_hit   = flg[0].valid && flg[0].frontier;
  assign mark_hit   = link_vld && link && flg[0].valid && !flg[0].visited;
  assign go_out     = !out_valid_q || out_acc;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc && last_particle_i) state_d = ST_SEED;
      ST_SEED: begin
        if (seed_hit)     state_d = ST_PICK;
        else if (rot_end) state_d = ST_DIVIDE;
      end
      ST_PICK: begin
        if (pick_hit)     state_d = ST_FEED;
        else if (rot_end) state_d = ST_SEED;
      end
      ST_FEED:   state_d = ST_WAIT;
      ST_WAIT:   if (link_vld) state_d = ST_STEP;
      ST_STEP:   state_d = rot_end ? ST_PICK : ST_FEED;
      ST_DIVIDE: if (div_done) state_d = ST_DONE;
      ST_DONE:   if (go_out) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    rotate = ((state_q == ST_SEED) && !seed_hit) ||
             ((state_q == ST_PICK) && !pick_hit) ||
             (state_q == ST_STEP);
    ctln.shift     = rotate || ((state_q == ST_IDLE) && in_acc && !full);
    ctln.clear     = (state_q == ST_DONE) && go_out;
    ctln.set_mark  = 1'b0;
    ctln.clr_front = 1'b0;
    ctl0           = ctln;
    ctl0.set_mark  = ((state_q == ST_SEED) && seed_hit) ||
                     ((state_q == ST_WAIT) && mark_hit);
    ctl0.clr_front = (state_q == ST_PICK) && pick_hit;
    pipe_vld       = (state_q == ST_FEED);
    if (state_q == ST_IDLE) begin
      crd0_in = {coord_z_i, coord_y_i, coord_x_i};
      flg0_in = '{valid: 1'b1, visited: 1'b0, frontier: 1'b0};
    end else begin
      crd0_in = crd[MAX_PARTICLES-1];
      flg0_in = flg[MAX_PARTICLES-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rot_q   <= '0;
      lc_q    <= '0;
      n_q     <= '0;
      clu_q   <= '0;
    end else begin
      state_q <= state_d;
      if (rotate && !rot_end) begin
        rot_q <= rot_q + 1'b1;
      end else if (rotate || state_q == ST_IDLE ||
                   (state_q == ST_SEED) || (state_q == ST_PICK)) begin
        rot_q <= '0;
      end
      if (in_acc) begin
        if (last_particle_i) begin
          n_q   <= full ? lc_q : lc_q + 1'b1;
          lc_q  <= '0;
          clu_q <= '0;
        end else if (!full) begin
          lc_q <= lc_q + 1'b1;
        end
      end
      if ((state_q == ST_SEED) && seed_hit) begin
        clu_q <= clu_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_PICK) && pick_hit) begin
      probe_q <= crd[0];
    end
  end

  // Cell row
  for (genvar i = 0; i < MAX_PARTICLES; i++) begin : g_cell
    if (i == 0) begin : g_head
      dcms_cell #(.CoordW(CW)) u_cell (
        .clk_i, .rst_ni, .ctl_i(ctl0), .crd_i(crd0_in), .flg_i(flg0_in),
        .crd_o(crd[i]), .flg_o(flg[i])
      );
    end else begin : g_body
      dcms_cell #(.CoordW(CW)) u_cell (
        .clk_i, .rst_ni, .ctl_i(ctln), .crd_i(crd[i-1]), .flg_i(flg[i-1]),
        .crd_o(crd[i]), .flg_o(flg[i])
      );
    end
  end

  dcms_dist #(.CoordBits(COORD_BITS)) u_dist (
    .clk_i, .rst_ni,
    .valid_i(pipe_vld), .probe_i(probe_q), .elem_i(crd[0]),
    .dims_i(dims_q), .box_i(box_q), .lim_i(lim_q),
    .valid_o(link_vld), .link_o(link)
  );

  // particles * 256 / clusters
  dcms_div #(.NumW(QW), .DenW(NW)) u_div (
    .clk_i, .rst_ni,
    .start_i((state_q == ST_SEED) && !seed_hit && rot_end),
    .num_i({n_q, 8'd0}), .den_i(clu_q),
    .done_o(div_done), .quo_o(quo)
  );

  // Result register
  logic [NW+8:0] clu_ext, n_ext;
  logic [QW+16:0] quo_ext;
  assign clu_ext = (NW+9)'(clu_q);
  assign n_ext   = (NW+9)'(n_q);
  assign quo_ext = (QW+17)'(quo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_DONE) && go_out) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && go_out) begin
      cc_q <= clu_ext[8:0];
      pt_q <= n_ext[8:0];
      ms_q <= quo_ext[16:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cluster_count_o  = cc_q;
  assign particle_total_o = pt_q;
  assign avg_size_o       = ms_q;

endmodule

// ===== hdl/dcms_check.sv =====
// Port-level checks for the distance cluster block, bound to the top level.
module dcms_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        last_particle_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [8:0]  cluster_count_o,
  input logic [8:0]  particle_total_o,
  input logic [16:0] avg_size_o
);

  // Result holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(cluster_count_o) && $stable(particle_total_o) && $stable(avg_size_o))
    else $error("result changed while stalled");

  // The last particle starts a clustering job, input must stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_particle_i |=> in_stall_o)
    else $error("input not stalled during clustering");

  // Every set has at least one cluster and no more clusters than particles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cluster_count_o != 9'd0) && (cluster_count_o <= particle_total_o))
    else $error("cluster count out of range");

endmodule

bind distance_cluster_mean_size dcms_check u_dcms_check (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for distance_cluster_mean_size.
`timescale 1ns / 100ps

module testbench;
  import dcms_pkg::*;

  localparam int unsigned MaxParticles = 256;
  localparam int unsigned RandomItems  = 1300;

  typedef struct {
    logic [8:0]  clusters;
    logic [8:0]  total;
    logic [16:0] mean;
  } cluster_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] coord_x_i = '0;
  logic [15:0] coord_y_i = '0;
  logic [15:0] coord_z_i = '0;
  logic        last_particle_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [8:0]  cluster_count_o;
  logic [8:0]  particle_total_o;
  logic [16:0] avg_size_o;

  distance_cluster_mean_size DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .coord_x_i, .coord_y_i, .coord_z_i,
    .last_particle_i, .out_valid_o, .out_stall_i,
    .cluster_count_o, .particle_total_o, .avg_size_o
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the configuration and of the particles held so far
  logic [15:0] box_len = 16'd2560;
  logic [1:0]  dims = 2'd3;
  logic [15:0] cutoff = 16'd512;
  logic signed [15:0] held_x[$], held_y[$], held_z[$];

  cluster_result_t expected_results[$];
  int  error_count = 0;
  int  items_sent = 0;
  bit  calm = 1'b0;       // no idling in the closing stretch
  bit  hold_req = 1'b0;   // ask the receiver for one long hold-off

  // Minimum-image link test between two held particles
  function automatic bit particles_linked(int a, int b);
    longint d, box;
    longint unsigned m, sum, lim;
    logic signed [15:0] pa, pb;
    sum = 0;
    box = longint'(box_len);
    lim = longint'(cutoff) * longint'(cutoff);
    for (int ax = 0; ax < 3 && ax < int'(dims); ax++) begin
      pa = (ax == 0) ? held_x[a] : (ax == 1) ? held_y[a] : held_z[a];
      pb = (ax == 0) ? held_x[b] : (ax == 1) ? held_y[b] : held_z[b];
      d = longint'(pa) - longint'(pb);
      if (2 * d > box) d -= box;
      else if (2 * d < -box) d += box;
      m = (d < 0) ? -d : d;
      if (m > 65535) return 1'b0;
      sum += m * m;
    end
    return sum < lim;
  endfunction

  // Breadth-first flood over the held set; gives count, total and mean
  function automatic cluster_result_t flood_clusters();
    cluster_result_t r;
    bit visited[MaxParticles];
    int frontier[$];
    int n, count, cur;
    n = held_x.size();
    count = 0;
    foreach (visited[i]) visited[i] = 1'b0;
    for (int seed = 0; seed < n; seed++) begin
      if (visited[seed]) continue;
      count++;
      visited[seed] = 1'b1;
      frontier.insert(frontier.size(), seed);
      while (frontier.size() > 0) begin
        cur = frontier.pop_front();
        for (int i = 0; i < n; i++)
          if (!visited[i] && particles_linked(cur, i)) begin
            visited[i] = 1'b1;
            frontier.insert(frontier.size(), i);
          end
      end
    end
    r.clusters = 9'(count);
    r.total    = 9'(n);
    r.mean     = (count != 0) ? 17'((n * 256) / count) : 17'd0;
    return r;
  endfunction

  // Offer one particle, wait until it is taken, then maybe idle a burst
  task automatic send_particle(logic [15:0] x, logic [15:0] y, logic [15:0] z, bit last);
    in_valid_i      <= 1'b1;
    coord_x_i       <= x;
    coord_y_i       <= y;
    coord_z_i       <= z;
    last_particle_i <= last;
    // stall is settled by the falling edge and holds until the next rise
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    items_sent++;
    if (held_x.size() < MaxParticles) begin
      held_x.insert(held_x.size(), x);
      held_y.insert(held_y.size(), y);
      held_z.insert(held_z.size(), z);
    end
    if (last) begin
      expected_results.insert(expected_results.size(), flood_clusters());
      held_x.delete(); held_y.delete(); held_z.delete();
    end
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_BOX_LENGTH: box_len = val;
      REG_DIMENSIONS: dims    = val[1:0];
      REG_CUTOFF:     cutoff  = val;
      default: ;
    endcase
  endtask

  task automatic configure(logic [15:0] box, logic [1:0] d, logic [15:0] cut);
    in_valid_i <= 1'b0;
    wait_idle();
    write_reg(REG_BOX_LENGTH, box);
    write_reg(REG_DIMENSIONS, 16'(d));
    write_reg(REG_CUTOFF, cut);
  endtask

  // One set of n particles; clustered sets sit around a few centers
  task automatic send_set(int n, bit scattered);
    int spread;
    logic [15:0] cx, cy, cz;
    spread = (cutoff == 0) ? 256 : int'(cutoff);
    cx = 16'($urandom); cy = 16'($urandom); cz = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      if (scattered)
        send_particle(16'($urandom), 16'($urandom), 16'($urandom), i == n - 1);
      else begin
        if ($urandom_range(0, 3) == 0) begin
          cx = 16'($urandom); cy = 16'($urandom); cz = 16'($urandom);
        end
        send_particle(cx + 16'($urandom_range(0, 2 * spread) - spread),
                      cy + 16'($urandom_range(0, 2 * spread) - spread),
                      cz + 16'($urandom_range(0, 2 * spread) - spread), i == n - 1);
      end
    end
  endtask

  // Receiver: random stall bursts, or one long hold-off on request
  always begin
    @(posedge clk_i);
    if (hold_req) begin
      out_stall_i <= 1'b1;
      repeat (20000) @(posedge clk_i);
      hold_req = 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Result checker; outputs are stable at the falling edge before acceptance
  always @(negedge clk_i) begin
    cluster_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: count %0d total %0d",
               cluster_count_o, particle_total_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (cluster_count_o !== want.clusters) begin
          $error("cluster_count expected %0d got %0d", want.clusters, cluster_count_o);
          error_count++;
        end
        if (particle_total_o !== want.total) begin
          $error("particle_total expected %0d got %0d", want.total, particle_total_o);
          error_count++;
        end
        if (avg_size_o !== want.mean) begin
          $error("avg_size expected %0d got %0d", want.mean, avg_size_o);
          error_count++;
        end
      end
    end
  end

  // Coordinate extremes, single particle, and a linked pair under reset config
  task automatic test_extremes();
    send_particle(16'h8000, 16'h7FFF, 16'h0000, 1'b1);
    send_particle(16'h7FFF, 16'h8000, 16'hFFFF, 1'b0);
    send_particle(16'h8000, 16'h7FFF, 16'h0001, 1'b0);
    send_particle(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_particle(16'h0100, 16'h0000, 16'h0000, 1'b1);
  endtask

  // Each dimension setting, zero included (everything links)
  task automatic test_dimensions();
    for (int d = 0; d < 4; d++) begin
      configure(16'd2560, 2'(d), 16'd512);
      send_particle(16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_particle(16'h0010, 16'h4000, 16'h0000, 1'b0);
      send_particle(16'h0010, 16'h0010, 16'h4000, 1'b1);
    end
  endtask

  // Zero cutoff isolates all; zero box disables wrapping; tiny box wraps hard
  task automatic test_cutoff_and_box();
    configure(16'd2560, 2'd3, 16'd0);
    send_set(4, 1'b0);
    configure(16'd0, 2'd1, 16'd65535);
    send_particle(16'h8000, 16'h0, 16'h0, 1'b0);
    send_particle(16'h7FFF, 16'h0, 16'h0, 1'b1);
    configure(16'd1, 2'd1, 16'd1);
    send_particle(16'h8000, 16'h0, 16'h0, 1'b0);
    send_particle(16'h7FFF, 16'h0, 16'h0, 1'b1);
    // wrap across the box edge: 0.5 and 9.5 in a box of 10 are 1.0 apart
    configure(16'd2560, 2'd1, 16'd512);
    send_particle(16'h0080, 16'h0, 16'h0, 1'b0);
    send_particle(16'h0980, 16'h0, 16'h0, 1'b1);
    configure(16'd65535, 2'd3, 16'd65535);
    send_set(3, 1'b1);
  endtask

  // Store full: the 257th particle is dropped but still ends the set
  task automatic test_store_full();
    configure(16'd2560, 2'd2, 16'd300);
    for (int i = 0; i <= MaxParticles; i++)
      send_particle(16'($urandom), 16'($urandom), 16'($urandom), i == MaxParticles);
  endtask

  // Receiver holds off while three sets are sent; the second must back up
  task automatic test_backpressure();
    configure(16'd2560, 2'd3, 16'd512);
    hold_req = 1'b1;
    send_set(3, 1'b0);
    send_set(3, 1'b0);
    send_set(2, 1'b0);
  endtask

  task automatic test_random();
    int start, n;
    start = items_sent;
    while (items_sent - start < RandomItems) begin
      if ($urandom_range(0, 15) == 0)
        case ($urandom_range(0, 4))
          0: configure(16'd2560, 2'd3, 16'd512);
          1: configure(16'd65535, 2'($urandom), 16'd65535);
          2: configure(16'd1, 2'($urandom), 16'd1);
          3: configure(16'd0, 2'($urandom), 16'($urandom_range(0, 2000)));
          default: configure(16'($urandom), 2'($urandom), 16'($urandom));
        endcase
      if (items_sent - start > RandomItems - 100) calm = 1'b1;
      n = ($urandom_range(0, 20) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      send_set(n, $urandom_range(0, 4) == 0);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_dimensions();
    test_cutoff_and_box();
    test_store_full();
    test_backpressure();
    test_random();
    in_valid_i <= 1'b0;
    wait_idle();
    if (error_count == 0) $display("** distance_cluster_mean_size: PASSED **");
    else $display("** distance_cluster_mean_size: FAILED **");
    $finish;
  end

  initial begin
    #500ms;
    $display("** distance_cluster_mean_size: FAILED **");
    $finish;
  end

endmodule
